// ===== rtl/cfs_pkg.sv =====
// Shared types, constants and the header text for the camera frame capture unit.
`default_nettype none
package cfs_pkg;

   localparam int unsigned WIDTH_W     = 10;
   localparam int unsigned HEIGHT_W    = 9;
   localparam int unsigned CSR_IDX_W   = 1;
   localparam int unsigned CSR_DATA_W  = 10;
   localparam int unsigned REQ_DATA_W  = 16;
   localparam int unsigned RSP_DATA_W  = 8;
   localparam int unsigned RSP_USER_W  = 2;
   localparam int unsigned HDR_LEN     = 5;
   localparam int unsigned HDR_IDX_W   = 3;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 10'd320;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 9'd240;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_START = 1'b1;

   localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = 3'd4;

   typedef enum logic [6:0] {
      PH_IDLE      = 7'b0000001,
      PH_VS_HIGH   = 7'b0000010,
      PH_VS_LOW    = 7'b0000100,
      PH_PX_LOW    = 7'b0001000,
      PH_SKIP_HIGH = 7'b0010000,
      PH_SKIP_LOW  = 7'b0100000,
      PH_END_HIGH  = 7'b1000000
   } phase_type;

   // One queued job for the output side: a whole header or a single pixel.
   typedef struct packed {
      logic       is_header;
      logic       frame_end;
      logic [7:0] pixel;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   function automatic logic [7:0] hdr_char(input logic [HDR_IDX_W-1:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h2A;
         3'd1:    ch = 8'h52;
         3'd2:    ch = 8'h44;
         3'd3:    ch = 8'h59;
         3'd4:    ch = 8'h2A;
         default: ch = 8'h2A;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/cfs_front.sv =====
// Request side: configuration registers, sync and pixel clock tracking, job generation.
`default_nettype none
module cfs_front (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire                             req_kind,
   input  wire                             vsync_level,
   input  wire                             pclk_level,
   input  wire  [3:0]                      data_low_nibble,
   input  wire  [3:0]                      data_high_nibble,
   input  wire                             csr_wr_en,
   input  wire  [cfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [cfs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  cfs_pkg::queue_stat_type         q_stat,
   output logic                            push,
   output cfs_pkg::cmd_type                push_cmd
);

   logic [cfs_pkg::WIDTH_W-1:0]  width_ff;
   logic [cfs_pkg::HEIGHT_W-1:0] height_ff;
   cfs_pkg::phase_type           phase_ff, phase_in;
   logic [cfs_pkg::WIDTH_W-1:0]  col_ff, col_in;
   logic [cfs_pkg::HEIGHT_W-1:0] rows_ff, rows_in;
   logic                         accept;

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      phase_in           = phase_ff;
      col_in             = col_ff;
      rows_in            = rows_ff;
      push               = 1'b0;
      push_cmd.is_header = 1'b0;
      push_cmd.frame_end = 1'b0;
      push_cmd.pixel     = {data_high_nibble, data_low_nibble};
      if (accept) begin
         if (req_kind == cfs_pkg::KIND_START) begin
            // A start abandons any capture in progress and re-arms.
            push               = 1'b1;
            push_cmd.is_header = 1'b1;
            rows_in            = height_ff;
            col_in             = width_ff;
            phase_in           = cfs_pkg::PH_VS_HIGH;
         end else begin
            case (phase_ff)
               cfs_pkg::PH_IDLE: begin
               end
               cfs_pkg::PH_VS_HIGH: begin
                  if (vsync_level) phase_in = cfs_pkg::PH_VS_LOW;
               end
               cfs_pkg::PH_VS_LOW: begin
                  if (!vsync_level) begin
                     if (rows_ff == '0 || col_ff == '0) phase_in = cfs_pkg::PH_IDLE;
                     else phase_in = cfs_pkg::PH_PX_LOW;
                  end
               end
               cfs_pkg::PH_PX_LOW: begin
                  if (!pclk_level) begin
                     push               = 1'b1;
                     push_cmd.frame_end = (col_ff <= 10'd1) && (rows_ff <= 9'd1);
                     phase_in           = cfs_pkg::PH_SKIP_HIGH;
                  end
               end
               cfs_pkg::PH_SKIP_HIGH: begin
                  if (pclk_level) phase_in = cfs_pkg::PH_SKIP_LOW;
               end
               cfs_pkg::PH_SKIP_LOW: begin
                  if (!pclk_level) phase_in = cfs_pkg::PH_END_HIGH;
               end
               cfs_pkg::PH_END_HIGH: begin
                  if (pclk_level) begin
                     if (col_ff > 10'd1) begin
                        col_in   = col_ff - 10'd1;
                        phase_in = cfs_pkg::PH_PX_LOW;
                     end else if (rows_ff > 9'd1) begin
                        // Each new row reloads its pixel count from the live register.
                        rows_in  = rows_ff - 9'd1;
                        col_in   = width_ff;
                        phase_in = (width_ff == '0) ? cfs_pkg::PH_IDLE : cfs_pkg::PH_PX_LOW;
                     end else begin
                        col_in   = '0;
                        rows_in  = '0;
                        phase_in = cfs_pkg::PH_IDLE;
                     end
                  end
               end
               default: phase_in = cfs_pkg::PH_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= cfs_pkg::WIDTH_RESET;
         height_ff <= cfs_pkg::HEIGHT_RESET;
         phase_ff  <= cfs_pkg::PH_IDLE;
         col_ff    <= '0;
         rows_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         col_ff   <= col_in;
         rows_ff  <= rows_in;
         if (csr_wr_en) begin
            case (csr_index)
               cfs_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[cfs_pkg::WIDTH_W-1:0];
               cfs_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata[cfs_pkg::HEIGHT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/cfs_queue.sv =====
// Short job queue between the capture front and the output back.
`default_nettype none
module cfs_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  cfs_pkg::cmd_type         push_cmd,
   input  wire                      pop,
   output cfs_pkg::cmd_type         head_cmd,
   output cfs_pkg::queue_stat_type  q_stat
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cfs_pkg::cmd_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign head_cmd     = mem_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_FULL);
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_stat.full && !pop))
      else $error("job queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_stat.empty))
      else $error("job queue read while empty");
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> !q_stat.empty)
      else $error("job queue empty after a write");
`endif

endmodule
`default_nettype wire

// ===== rtl/cfs_back.sv =====
// Output side: expands queued jobs into header and pixel bytes behind an output register.
`default_nettype none
module cfs_back (
   input  wire                              clock,
   input  wire                              reset,
   input  cfs_pkg::cmd_type                 head_cmd,
   input  cfs_pkg::queue_stat_type          q_stat,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [cfs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [cfs_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                             rsp_tlast
);

   logic [cfs_pkg::HDR_IDX_W-1:0]  hdr_idx_ff, hdr_idx_in;
   logic                           valid_ff;
   logic [cfs_pkg::RSP_DATA_W-1:0] data_ff, data_in;
   logic [cfs_pkg::RSP_USER_W-1:0] user_ff, user_in;
   logic                           last_ff, last_in;
   logic                           load;

   assign load = !q_stat.empty && (!valid_ff || rsp_tready);

   always_comb begin
      hdr_idx_in = hdr_idx_ff;
      pop        = 1'b0;
      if (head_cmd.is_header) begin
         data_in = cfs_pkg::hdr_char(hdr_idx_ff);
         user_in = {1'b0, 1'b1};
         last_in = (hdr_idx_ff == cfs_pkg::HDR_LAST_IDX);
      end else begin
         data_in = head_cmd.pixel;
         user_in = {head_cmd.frame_end, 1'b0};
         last_in = 1'b1;
      end
      if (load) begin
         // A header job stays at the queue head until its fifth byte is loaded into the output register.
         pop        = last_in;
         hdr_idx_in = last_in ? '0 : hdr_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         hdr_idx_ff <= '0;
      end else begin
         hdr_idx_ff <= hdr_idx_in;
         if (load)            valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         user_ff <= user_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

// ===== rtl/camera_frame_capture_to_serial_unit.sv =====
// Top level of the camera frame capture unit feeding a byte serial link.
//
//  Group   Role     Payload
//  req_    in       tuser: kind; tdata: vsync, pclk, data[3:0], data[7:4]
//  rsp_    out      tdata: byte; tuser: is_header, frame_end; tlast: last of request
//  csr_    write    index 0 frame_width, index 1 frame_height
//
// Every request is accepted whenever the job queue has room; a start
// request becomes one queued job that leaves as five header bytes, a pixel
// as one byte. The output register emits one byte per cycle while rsp_tready
// holds, so header bursts set the sustained rate when starts follow closely.
// Reset is synchronous and returns to idle with the default frame size.
// A stalled output fills the queue, and only then is req_tready dropped.
`default_nettype none
module camera_frame_capture_to_serial_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [cfs_pkg::REQ_DATA_W-1:0]   req_tdata,  // vsync, pclk, data[3:0], data[7:4], pad
   input  wire                              req_tuser,  // kind
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [cfs_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // out_byte
   output logic [cfs_pkg::RSP_USER_W-1:0]   rsp_tuser,  // is_header, frame_end
   output logic                             rsp_tlast,
   input  wire                              csr_wr_en,
   input  wire  [cfs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [cfs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic                    push;
   logic                    pop;
   cfs_pkg::cmd_type        push_cmd;
   cfs_pkg::cmd_type        head_cmd;
   cfs_pkg::queue_stat_type q_stat;

   cfs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_kind         (req_tuser),
      .vsync_level      (req_tdata[0]),
      .pclk_level       (req_tdata[1]),
      .data_low_nibble  (req_tdata[5:2]),
      .data_high_nibble (req_tdata[9:6]),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .q_stat           (q_stat),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   cfs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_stat   (q_stat)
   );

   cfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the camera frame capture unit: directed and random capture runs.
module testbench;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 20;
   // The ready header, first character in the top byte.
   localparam logic [39:0] READY_BANNER = "*RDY*";

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [cfs_pkg::REQ_DATA_W-1:0] req_tdata = '0;  // vsync, pclk, data[3:0], data[7:4], zero pad
   logic req_tuser = 1'b0;                          // kind
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [cfs_pkg::RSP_DATA_W-1:0] rsp_tdata;       // out_byte
   logic [cfs_pkg::RSP_USER_W-1:0] rsp_tuser;       // is_header, frame_end
   logic rsp_tlast;
   logic csr_wr_en = 1'b0;
   logic [cfs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [cfs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int cycles = 0;
   int items_sent = 0;
   int send_idle = 25;
   int recv_idle = 54;

   camera_frame_capture_to_serial_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   class capture_scoreboard;
      typedef struct {
         logic [7:0] data;
         logic       header;
         logic       last;
         logic       frame_end;
      } serial_byte_type;

      logic [cfs_pkg::WIDTH_W-1:0]  width_reg;
      logic [cfs_pkg::HEIGHT_W-1:0] height_reg;
      cfs_pkg::phase_type           phase;
      logic [cfs_pkg::WIDTH_W-1:0]  columns_left;
      logic [cfs_pkg::HEIGHT_W-1:0] rows_left;
      serial_byte_type              expected_bytes[$];
      int                           errors;

      function new();
         width_reg = cfs_pkg::WIDTH_RESET;
         height_reg = cfs_pkg::HEIGHT_RESET;
         phase = cfs_pkg::PH_IDLE;
         columns_left = '0;
         rows_left = '0;
         errors = 0;
      endfunction

      function void write_register(logic [cfs_pkg::CSR_IDX_W-1:0] idx,
                                   logic [cfs_pkg::CSR_DATA_W-1:0] value);
         if (idx == cfs_pkg::CSR_FRAME_WIDTH) begin
            width_reg = value[cfs_pkg::WIDTH_W-1:0];
         end else begin
            height_reg = value[cfs_pkg::HEIGHT_W-1:0];
         end
      endfunction

      function bit busy();
         return phase != cfs_pkg::PH_IDLE;
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      function void push_byte(logic [7:0] data, logic header, logic last, logic frame_end);
         serial_byte_type entry;
         entry.data = data;
         entry.header = header;
         entry.last = last;
         entry.frame_end = frame_end;
         expected_bytes.push_back(entry);
      endfunction

      function void note_request(logic kind, logic vs, logic pc, logic [3:0] lo, logic [3:0] hi);
         int k;
         if (kind == cfs_pkg::KIND_START) begin
            // A start always restarts from scratch, whatever was in progress.
            for (k = 0; k < cfs_pkg::HDR_LEN; k++) begin
               push_byte(READY_BANNER[39-8*k -: 8], 1'b1, k == cfs_pkg::HDR_LEN - 1, 1'b0);
            end
            rows_left = height_reg;
            columns_left = width_reg;
            phase = cfs_pkg::PH_VS_HIGH;
         end else begin
            case (phase)
               cfs_pkg::PH_IDLE: ;
               cfs_pkg::PH_VS_HIGH: begin
                  if (vs) phase = cfs_pkg::PH_VS_LOW;
               end
               cfs_pkg::PH_VS_LOW: begin
                  if (!vs) begin
                     phase = (rows_left == 0 || columns_left == 0) ? cfs_pkg::PH_IDLE
                                                                   : cfs_pkg::PH_PX_LOW;
                  end
               end
               cfs_pkg::PH_PX_LOW: begin
                  if (!pc) begin
                     push_byte({hi, lo}, 1'b0, 1'b1, columns_left <= 1 && rows_left <= 1);
                     phase = cfs_pkg::PH_SKIP_HIGH;
                  end
               end
               cfs_pkg::PH_SKIP_HIGH: begin
                  if (pc) phase = cfs_pkg::PH_SKIP_LOW;
               end
               cfs_pkg::PH_SKIP_LOW: begin
                  if (!pc) phase = cfs_pkg::PH_END_HIGH;
               end
               cfs_pkg::PH_END_HIGH: begin
                  if (pc) begin
                     if (columns_left > 1) begin
                        columns_left = columns_left - 1'b1;
                        phase = cfs_pkg::PH_PX_LOW;
                     end else if (rows_left > 1) begin
                        // A new row takes its length from the register as it stands now.
                        rows_left = rows_left - 1'b1;
                        columns_left = width_reg;
                        phase = (columns_left == 0) ? cfs_pkg::PH_IDLE : cfs_pkg::PH_PX_LOW;
                     end else begin
                        columns_left = '0;
                        rows_left = '0;
                        phase = cfs_pkg::PH_IDLE;
                     end
                  end
               end
               default: phase = cfs_pkg::PH_IDLE;
            endcase
         end
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at cycle %0d: %s", cycles, msg);
         errors++;
      endtask

      task check_response(logic [7:0] data, logic [1:0] user, logic last);
         serial_byte_type want;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", data));
         end else begin
            want = expected_bytes.pop_front();
            if (data !== want.data)
               report_mismatch($sformatf("byte %02h, wanted %02h", data, want.data));
            if (user[0] !== want.header)
               report_mismatch($sformatf("header flag %b, wanted %b", user[0], want.header));
            if (user[1] !== want.frame_end)
               report_mismatch($sformatf("frame end %b, wanted %b", user[1], want.frame_end));
            if (last !== want.last)
               report_mismatch($sformatf("last flag %b, wanted %b", last, want.last));
         end
      endtask
   endclass

   capture_scoreboard scoreboard = new();

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         scoreboard.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   task automatic send_request(input logic kind, input logic vs, input logic pc,
                               input logic [3:0] lo, input logic [3:0] hi);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {6'b0, hi, lo, pc, vs};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      scoreboard.note_request(kind, vs, pc, lo, hi);
      items_sent++;
   endtask

   task automatic tick(input logic vs, input logic pc, input logic [3:0] lo, input logic [3:0] hi);
      send_request(cfs_pkg::KIND_TICK, vs, pc, lo, hi);
   endtask

   task automatic start_capture();
      send_request(cfs_pkg::KIND_START, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   4'($urandom_range(15)), 4'($urandom_range(15)));
   endtask

   // Holds the sender off until every expected byte is out, then lets the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_size(input logic [cfs_pkg::WIDTH_W-1:0] w,
                                   input logic [cfs_pkg::HEIGHT_W-1:0] h);
      csr_wr_en <= 1'b1;
      csr_index <= cfs_pkg::CSR_FRAME_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      scoreboard.write_register(cfs_pkg::CSR_FRAME_WIDTH, w);
      csr_index <= cfs_pkg::CSR_FRAME_HEIGHT;
      csr_wdata <= {1'b0, h};
      @(posedge clock);
      scoreboard.write_register(cfs_pkg::CSR_FRAME_HEIGHT, {1'b0, h});
      csr_wr_en <= 1'b0;
   endtask

   // A well-formed capture with random pin content; sometimes cut short by the next start.
   task automatic run_frame();
      int n;
      int cap;
      logic pc;
      start_capture();
      repeat ($urandom_range(2)) tick(1'b0, 1'($urandom_range(1)), 4'($urandom_range(15)),
                                      4'($urandom_range(15)));
      repeat ($urandom_range(1, 3)) tick(1'b1, 1'($urandom_range(1)), 4'($urandom_range(15)),
                                          4'($urandom_range(15)));
      tick(1'b0, 1'($urandom_range(1)), 4'($urandom_range(15)), 4'($urandom_range(15)));
      if (scoreboard.width_reg * scoreboard.height_reg > 40 || $urandom_range(9) == 0) begin
         cap = $urandom_range(4, 20);
      end else begin
         cap = 2000;
      end
      pc = 1'($urandom_range(1));
      n = 0;
      while (scoreboard.busy() && n < cap) begin
         if ($urandom_range(99) < 75) pc = ~pc;
         tick($urandom_range(15) == 0, pc, 4'($urandom_range(15)), 4'($urandom_range(15)));
         n++;
      end
   endtask

   task automatic run_noise();
      repeat ($urandom_range(3, 8)) begin
         send_request($urandom_range(7) == 0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      4'($urandom_range(15)), 4'($urandom_range(15)));
      end
   endtask

   function automatic logic [cfs_pkg::WIDTH_W-1:0] pick_width();
      int r;
      r = $urandom_range(99);
      if (r < 4) return '0;
      if (r < 10) return 10'd1023;
      if (r < 20) return 10'd1;
      return 10'($urandom_range(1, 5));
   endfunction

   function automatic logic [cfs_pkg::HEIGHT_W-1:0] pick_height();
      int r;
      r = $urandom_range(99);
      if (r < 4) return '0;
      if (r < 10) return 9'd511;
      if (r < 20) return 9'd1;
      return 9'($urandom_range(1, 3));
   endfunction

   initial begin
      int mode;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Zero height at the widest row: frame sync low sends the block straight back to idle.
      write_frame_size(10'd1023, 9'd0);
      send_request(cfs_pkg::KIND_START, 1'b1, 1'b1, 4'hF, 4'hF);
      tick(1'b1, 1'b0, 4'h0, 4'h0);
      tick(1'b0, 1'b0, 4'h0, 4'h0);
      tick(1'b0, 1'b0, 4'h5, 4'hA);

      // Two pixels in one row, all-zero then all-one data, with the trailing waits.
      drain();
      write_frame_size(10'd2, 9'd1);
      send_request(cfs_pkg::KIND_START, 1'b0, 1'b0, 4'h0, 4'h0);
      tick(1'b0, 1'b1, 4'h3, 4'h3);
      tick(1'b1, 1'b1, 4'h3, 4'h3);
      tick(1'b0, 1'b0, 4'hC, 4'hC);   // ends the sync wait, must not count as a pixel
      tick(1'b0, 1'b0, 4'h0, 4'h0);
      tick(1'b0, 1'b0, 4'h9, 4'h9);
      tick(1'b0, 1'b1, 4'h9, 4'h9);
      tick(1'b0, 1'b0, 4'h9, 4'h9);
      tick(1'b0, 1'b1, 4'h9, 4'h9);
      tick(1'b0, 1'b0, 4'hF, 4'hF);
      tick(1'b0, 1'b1, 4'h1, 4'h1);
      tick(1'b0, 1'b0, 4'h1, 4'h1);
      tick(1'b0, 1'b1, 4'h1, 4'h1);

      // Tallest frame, abandoned by a second start after one pixel.
      drain();
      write_frame_size(10'd1, 9'd511);
      start_capture();
      tick(1'b1, 1'b0, 4'h0, 4'h0);
      tick(1'b0, 1'b1, 4'h0, 4'h0);
      tick(1'b0, 1'b0, 4'h6, 4'hB);
      tick(1'b0, 1'b1, 4'h6, 4'hB);
      tick(1'b1, 1'b0, 4'h6, 4'hB);
      start_capture();

      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_idle = 25; recv_idle = 54; end
            1: begin send_idle = 54; recv_idle = 25; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         while (items_sent < (mode + 1) * 125) begin
            drain();
            write_frame_size(pick_width(), pick_height());
            repeat ($urandom_range(2, 4)) begin
               if ($urandom_range(9) < 8) begin
                  run_frame();
               end else begin
                  run_noise();
               end
            end
         end
      end

      drain();
      repeat (30) @(posedge clock);
      if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/cfs_pkg.sv
rtl/cfs_front.sv
rtl/cfs_queue.sv
rtl/cfs_back.sv
rtl/camera_frame_capture_to_serial_unit.sv
test/testbench.sv
